### rtl/terminal_text_sanitizer_assert.svh
// Assertion macros for the checker file of the text sanitizer.
// No dependencies; take in with `include before the checker module.
`ifndef TERMINAL_TEXT_SANITIZER_ASSERT_SVH
`define TERMINAL_TEXT_SANITIZER_ASSERT_SVH

// Check a property outside reset.
`define TTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: sanitizer check failed");

// Check a property at every edge, reset included.
`define TTS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: sanitizer check failed");

`endif

### rtl/ttsan_pkg.sv
// Types, byte codes and helpers of the terminal text sanitizer.
// No dependencies; used by every module of the block.
package ttsan_pkg;

   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] BYTE_LEAD  = 8'hC2;
   localparam logic [7:0] C1_LO      = 8'h80;
   localparam logic [7:0] C1_HI      = 8'h9F;
   localparam logic [7:0] REPL_0     = 8'hEF;
   localparam logic [7:0] REPL_1     = 8'hBF;
   localparam logic [7:0] REPL_2     = 8'hBD;
   localparam logic [1:0] CONT_TAG   = 2'b10;

   // What a request emits after the optional held lead byte.
   typedef enum logic [1:0] {
      BODY_NONE  = 2'd0,
      BODY_BYTE  = 2'd1,
      BODY_SPACE = 2'd2,
      BODY_REPL  = 2'd3
   } body_type;

   typedef struct packed {
      logic       pfx;     // emit the held 0xC2 first
      body_type   body;
      logic [7:0] value;   // byte for BODY_BYTE
      logic [2:0] nspace;  // 1..4 for BODY_SPACE
   } job_type;

   function automatic logic [2:0] body_len(input body_type body, input logic [2:0] nspace);
      logic [2:0] len;
      unique case (body)
         BODY_NONE:  len = 3'd0;
         BODY_BYTE:  len = 3'd1;
         BODY_SPACE: len = nspace;
         BODY_REPL:  len = 3'd3;
         default:    len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

### rtl/ttsan_front.sv
// Front part: accepts request bytes, tracks column and held lead byte,
// and turns each request into an output job. Uses ttsan_pkg.
module ttsan_front import ttsan_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] in_byte,
   input  logic       line_end,
   input  logic       q_ready,
   output logic       push,
   output job_type    job
);

   logic [1:0] phase_ff, phase_in;
   logic       held_ff, held_in;
   logic       accept, pair;
   logic [1:0] phase_a;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;

   always_comb begin
      pair      = held_ff && (in_byte >= C1_LO) && (in_byte <= C1_HI);
      job.pfx   = held_ff && !pair;
      job.value = in_byte;
      job.nspace = 3'd0;
      job.body  = BODY_NONE;
      phase_a   = phase_ff + {1'b0, job.pfx};
      phase_in  = phase_a;
      held_in   = 1'b0;
      if (pair) begin
         job.body = BODY_REPL;
         phase_in = phase_ff + 2'd1;
      end else if (in_byte == BYTE_CR) begin
         job.body = BODY_NONE;
      end else if (in_byte == BYTE_TAB) begin
         job.body   = BODY_SPACE;
         job.nspace = 3'd4 - {1'b0, phase_a};
         phase_in   = 2'd0;
      end else if ((in_byte < BYTE_SPACE) || (in_byte == BYTE_DEL)) begin
         job.body = BODY_REPL;
         phase_in = phase_a + 2'd1;
      end else if ((in_byte == BYTE_LEAD) && !line_end) begin
         held_in = 1'b1;
      end else begin
         job.body = BODY_BYTE;
         if (in_byte[7:6] != CONT_TAG) phase_in = phase_a + 2'd1;
      end
      if (line_end) begin
         phase_in = 2'd0;
         held_in  = 1'b0;
      end
   end

   // Requests that emit nothing never enter the queue.
   assign push = accept && (job.pfx || (job.body != BODY_NONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         held_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

### rtl/ttsan_fifo.sv
// Short job queue between front and back of the sanitizer.
// Uses ttsan_pkg for the job type.
module ttsan_fifo import ttsan_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [CNT_W-1:0]   cnt_ff;

   assign not_full  = (cnt_ff != CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_job  = mem_ff[rd_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= next_ptr(wr_ff);
         if (pop)  rd_ff <= next_ptr(rd_ff);
         if (push && !pop)      cnt_ff <= cnt_ff + CNT_W'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

endmodule

### rtl/ttsan_back.sv
// Back part: plays out one job byte by byte on the response channel.
// Uses ttsan_pkg for the job type and length helper.
module ttsan_back import ttsan_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  job_type    q_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] out_byte,
   output logic       run_end
);

   job_type    job_ff;
   logic [2:0] idx_ff;
   logic       busy_ff;
   logic [2:0] total, j;

   always_comb begin
      total   = {2'b00, job_ff.pfx} + body_len(job_ff.body, job_ff.nspace);
      run_end = (idx_ff == total - 3'd1);
      j       = idx_ff - {2'b00, job_ff.pfx};
      if (job_ff.pfx && (idx_ff == 3'd0)) begin
         out_byte = BYTE_LEAD;
      end else begin
         case (job_ff.body)
            BODY_BYTE:  out_byte = job_ff.value;
            BODY_SPACE: out_byte = BYTE_SPACE;
            BODY_REPL:  out_byte = (j == 3'd0) ? REPL_0 : ((j == 3'd1) ? REPL_1 : REPL_2);
            default:    out_byte = job_ff.value;
         endcase
      end
   end

   assign rsp_valid = busy_ff;
   // Load the next job when idle or as the last byte leaves.
   assign pop = q_valid && (!busy_ff || (rsp_ready && run_end));

   always_ff @(posedge clock) begin
      if (pop) job_ff <= q_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= 3'd0;
      end else if (busy_ff && rsp_ready) begin
         if (run_end) busy_ff <= 1'b0;
         else         idx_ff  <= idx_ff + 3'd1;
      end
   end

endmodule

### rtl/terminal_text_sanitizer.sv
// Channel | Dir | Ports                                        | Carries
// req     | in  | req_valid req_ready req_in_byte req_line_end | one raw line byte
// rsp     | out | rsp_valid rsp_ready rsp_out_byte rsp_run_end | one cleaned byte
//
// One request is taken per cycle while the job queue has room. Bytes leave rsp
// one per cycle while rsp_ready is high; a request costs one transfer per byte
// it emits (0 to 5), so tabs and replacements set the sustained rate.
// Reset is synchronous: column, held lead byte, queue and output clear.
// The two sides stall on their own through the QUEUE_DEPTH job queue.
// Depends on ttsan_pkg, ttsan_front, ttsan_fifo and ttsan_back.
module terminal_text_sanitizer import ttsan_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end
);

   job_type front_job, head_job;
   logic    push, not_full, not_empty, pop;

   // Classify each request and keep column and held lead byte up to date.
   ttsan_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .in_byte   (req_in_byte),
      .line_end  (req_line_end),
      .q_ready   (not_full),
      .push      (push),
      .job       (front_job)
   );

   // Hold jobs so the front keeps taking requests while the back stalls.
   ttsan_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (front_job),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   // Advance through each job one output byte per accepted response.
   ttsan_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (not_empty),
      .q_job     (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .out_byte  (rsp_out_byte),
      .run_end   (rsp_run_end)
   );

endmodule

### rtl/ttsan_checker.sv
// Port-level checks of the terminal text sanitizer, bound to the top level.
// Depends on terminal_text_sanitizer_assert.svh.
`include "terminal_text_sanitizer_assert.svh"

module ttsan_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_end
);

   // A stalled response holds its byte and marker.
   `TTS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_end))

   // No C0 control byte and no DEL ever reaches the output.
   `TTS_ASSERT(a_no_ctrl, clock, reset, rsp_valid |-> !((rsp_out_byte < 8'h20) || (rsp_out_byte == 8'h7F)))

   // Reset leaves the output idle and the input open.
   `TTS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind terminal_text_sanitizer ttsan_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_run_end  (rsp_run_end)
);
